// ----- rtl/pwfm_pkg.sv -----
// Shared widths, constants and types for the pulse width and frequency meter.
package pwfm_pkg;

    // Field widths
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int CLK_HZ_W   = 32;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Divider works one bit wider so the frequency divisor (sum of two averages) fits
    localparam int DIV_W = 33;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 2;

    // Register reset values
    localparam logic [CLK_HZ_W-1:0]   CLOCK_HZ_RESET        = 32'd160000000;
    localparam logic [INTERVAL_W-1:0] REPORT_INTERVAL_RESET = 16'd20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Which quotient the shared divider is producing
    typedef enum logic [1:0] {
        OP_MOD,
        OP_HIGH,
        OP_LOW,
        OP_FREQ
    } div_op_t;

endpackage

// ----- rtl/pwfm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module pwfm_div
    import pwfm_pkg::*;
#(
    parameter int WIDTH = DIV_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);
    localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(WIDTH);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0]    quo_reg, quo_next;
    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    dsr_reg, dsr_next;

    logic [WIDTH:0]      shifted;
    logic [WIDTH:0]      diff;
    logic                fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[WIDTH-2:0], fits};
            rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control under reset, operands need none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/pulse_width_frequency_meter.sv -----
// Pulse width and frequency meter: edge detection, running sums and report sequencer.
// Flow: a steady or priming sample's result is registered and shown in the cycle after acceptance;
// an edge runs one divider pass (launch, 33 steps, hand-off) for the report check, and a report
// edge adds three passes (averages, frequency), skipping any pass whose divisor is zero.
// Throughput: one sample at a time; a steady sample every cycle while results drain.
// Reset (aresetn low, synchronous): block unprimed, sums and counts zero, registers to defaults.
module pulse_width_frequency_meter
    import pwfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // Sample requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // level[0], stamp[32:1], zero pad
    // Result requests
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // rising[0], segment_cycles[32:1],
                                              // edge_number[64:33], avg_high_cycles[96:65],
                                              // avg_low_cycles[128:97],
                                              // freq_estimate_hz[160:129], zero pad
    output logic [OUT_TUSER_W-1:0] m_tuser    // edge_seen[0], stats_valid[1]
);

    // Configuration
    logic [CLK_HZ_W-1:0]   clock_hz_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    // Measurement state
    state_t              state_reg, state_next;
    div_op_t             op_reg, op_next;
    logic                primed_reg, primed_next;
    logic                last_level_reg, last_level_next;
    logic [STAMP_W-1:0]  last_stamp_reg, last_stamp_next;
    logic [CNT_W-1:0]    edges_reg, edges_next;
    logic [CNT_W-1:0]    high_total_reg, high_total_next;
    logic [CNT_W-1:0]    low_total_reg, low_total_next;
    logic [CNT_W-1:0]    high_seg_reg, high_seg_next;
    logic [CNT_W-1:0]    low_seg_reg, low_seg_next;

    // Pending edge result
    logic                pend_rising_reg, pend_rising_next;
    logic [CNT_W-1:0]    pend_seg_reg, pend_seg_next;
    logic                stats_reg, stats_next;
    logic [CNT_W-1:0]    avg_high_reg, avg_high_next;
    logic [CNT_W-1:0]    avg_low_reg, avg_low_next;
    logic [CNT_W-1:0]    freq_reg, freq_next;

    // Output stage
    logic                m_valid_reg, m_valid_next;
    logic                out_edge_reg, out_edge_next;
    logic                out_rising_reg, out_rising_next;
    logic [CNT_W-1:0]    out_seg_reg, out_seg_next;
    logic [CNT_W-1:0]    out_edges_reg, out_edges_next;
    logic                out_stats_reg, out_stats_next;
    logic [CNT_W-1:0]    out_ah_reg, out_ah_next;
    logic [CNT_W-1:0]    out_al_reg, out_al_next;
    logic [CNT_W-1:0]    out_freq_reg, out_freq_next;

    // Divider hookup
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;
    logic [DIV_W-1:0]    div_rem;

    logic                in_level;
    logic [STAMP_W-1:0]  in_stamp;
    logic [STAMP_W-1:0]  seg_len;
    logic                out_free;
    logic                in_acc;
    logic [DIV_W-1:0]    avg_sum;

    assign in_level = s_tdata[0];
    assign in_stamp = s_tdata[STAMP_W:1];
    assign seg_len  = in_stamp - last_stamp_reg;
    assign avg_sum  = {1'b0, avg_high_reg} + {1'b0, avg_low_reg};

    // Output register free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Divider operands follow the current operation
    always_comb begin
        unique case (op_reg)
            OP_MOD: begin
                div_dividend = {1'b0, edges_reg};
                div_divisor  = DIV_W'(interval_reg);
            end
            OP_HIGH: begin
                div_dividend = {1'b0, high_total_reg};
                div_divisor  = {1'b0, high_seg_reg};
            end
            OP_LOW: begin
                div_dividend = {1'b0, low_total_reg};
                div_divisor  = {1'b0, low_seg_reg};
            end
            OP_FREQ: begin
                div_dividend = {1'b0, clock_hz_reg};
                div_divisor  = avg_sum;
            end
        endcase
    end

    pwfm_div #(
        .WIDTH (DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer: accept samples, run report check and divisions, load results
    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        primed_next      = primed_reg;
        last_level_next  = last_level_reg;
        last_stamp_next  = last_stamp_reg;
        edges_next       = edges_reg;
        high_total_next  = high_total_reg;
        low_total_next   = low_total_reg;
        high_seg_next    = high_seg_reg;
        low_seg_next     = low_seg_reg;
        pend_rising_next = pend_rising_reg;
        pend_seg_next    = pend_seg_reg;
        stats_next       = stats_reg;
        avg_high_next    = avg_high_reg;
        avg_low_next     = avg_low_reg;
        freq_next        = freq_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_edge_next    = out_edge_reg;
        out_rising_next  = out_rising_reg;
        out_seg_next     = out_seg_reg;
        out_edges_next   = out_edges_reg;
        out_stats_next   = out_stats_reg;
        out_ah_next      = out_ah_reg;
        out_al_next      = out_al_reg;
        out_freq_next    = out_freq_reg;
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    last_level_next = in_level;
                    last_stamp_next = in_stamp;
                    if (primed_reg && (in_level != last_level_reg)) begin
                        // Count the edge and close the segment
                        edges_next       = edges_reg + 1'b1;
                        pend_rising_next = in_level;
                        pend_seg_next    = seg_len;
                        if (last_level_reg) begin
                            high_total_next = high_total_reg + seg_len;
                            high_seg_next   = high_seg_reg + 1'b1;
                        end else begin
                            low_total_next = low_total_reg + seg_len;
                            low_seg_next   = low_seg_reg + 1'b1;
                        end
                        stats_next    = 1'b0;
                        avg_high_next = '0;
                        avg_low_next  = '0;
                        freq_next     = '0;
                        op_next       = OP_MOD;
                        state_next    = ST_LAUNCH;
                    end else begin
                        // Priming or steady sample: result right away
                        primed_next     = 1'b1;
                        m_valid_next    = 1'b1;
                        out_edge_next   = 1'b0;
                        out_rising_next = 1'b0;
                        out_seg_next    = '0;
                        out_edges_next  = primed_reg ? edges_reg : '0;
                        out_stats_next  = 1'b0;
                        out_ah_next     = '0;
                        out_al_next     = '0;
                        out_freq_next   = '0;
                    end
                end
            end
            ST_LAUNCH: begin
                unique case (op_reg)
                    OP_MOD: begin
                        if ((interval_reg == '0) || (edges_reg == '0)) begin
                            state_next = ST_OUT;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_WAIT;
                        end
                    end
                    OP_HIGH: begin
                        if (high_seg_reg == '0) begin
                            avg_high_next = '0;
                            op_next       = OP_LOW;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_WAIT;
                        end
                    end
                    OP_LOW: begin
                        if (low_seg_reg == '0) begin
                            avg_low_next = '0;
                            op_next      = OP_FREQ;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_WAIT;
                        end
                    end
                    OP_FREQ: begin
                        if (avg_sum == '0) begin
                            freq_next  = '0;
                            stats_next = 1'b1;
                            state_next = ST_OUT;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_WAIT;
                        end
                    end
                endcase
            end
            ST_WAIT: begin
                if (div_done) begin
                    unique case (op_reg)
                        OP_MOD: begin
                            if (div_rem == '0) begin
                                op_next    = OP_HIGH;
                                state_next = ST_LAUNCH;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        OP_HIGH: begin
                            avg_high_next = div_quo[CNT_W-1:0];
                            op_next       = OP_LOW;
                            state_next    = ST_LAUNCH;
                        end
                        OP_LOW: begin
                            avg_low_next = div_quo[CNT_W-1:0];
                            op_next      = OP_FREQ;
                            state_next   = ST_LAUNCH;
                        end
                        OP_FREQ: begin
                            freq_next  = div_quo[CNT_W-1:0];
                            stats_next = 1'b1;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                // Load the edge result once the output stage is free
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_edge_next   = 1'b1;
                    out_rising_next = pend_rising_reg;
                    out_seg_next    = pend_seg_reg;
                    out_edges_next  = edges_reg;
                    out_stats_next  = stats_reg;
                    out_ah_next     = avg_high_reg;
                    out_al_next     = avg_low_reg;
                    out_freq_next   = freq_reg;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    // Control and measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_MOD;
            primed_reg     <= 1'b0;
            last_level_reg <= 1'b0;
            last_stamp_reg <= '0;
            edges_reg      <= '0;
            high_total_reg <= '0;
            low_total_reg  <= '0;
            high_seg_reg   <= '0;
            low_seg_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            primed_reg     <= primed_next;
            last_level_reg <= last_level_next;
            last_stamp_reg <= last_stamp_next;
            edges_reg      <= edges_next;
            high_total_reg <= high_total_next;
            low_total_reg  <= low_total_next;
            high_seg_reg   <= high_seg_next;
            low_seg_reg    <= low_seg_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_rising_reg <= pend_rising_next;
        pend_seg_reg    <= pend_seg_next;
        stats_reg       <= stats_next;
        avg_high_reg    <= avg_high_next;
        avg_low_reg     <= avg_low_next;
        freq_reg        <= freq_next;
        out_edge_reg    <= out_edge_next;
        out_rising_reg  <= out_rising_next;
        out_seg_reg     <= out_seg_next;
        out_edges_reg   <= out_edges_next;
        out_stats_reg   <= out_stats_next;
        out_ah_reg      <= out_ah_next;
        out_al_reg      <= out_al_next;
        out_freq_reg    <= out_freq_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            interval_reg <= REPORT_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CLOCK_HZ:        clock_hz_reg <= cfg_wr_data[CLK_HZ_W-1:0];
                REG_REPORT_INTERVAL: interval_reg <= cfg_wr_data[INTERVAL_W-1:0];
            endcase
        end
    end

    // Drive result channel
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {out_stats_reg, out_edge_reg};
    assign m_tdata  = {7'b0, out_freq_reg, out_al_reg, out_ah_reg, out_edges_reg,
                       out_seg_reg, out_rising_reg};

    // Samples are taken only when the sequencer is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("sample accepted while sequencer busy");

    // Statistics only ride on an edge result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("stats reported without an edge");

    // Divider never restarted mid-operation
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (!div_busy && (state_reg == ST_LAUNCH)))
        else $error("divider started while busy");

    // A completed division is always consumed in the wait state
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WAIT))
        else $error("division finished outside wait state");

endmodule
